// File: rtl/pnc_pkg.sv
// pnc_pkg: shared constants and types for the preamble normalized correlator
// tap offsets, score format and sequencer states; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pnc_pkg;

	// width of the sample port
	localparam int unsigned SAMPLE_PORT_W = 16;

	// correlation taps, offset 0 is the oldest sample of the window
	localparam int unsigned TAP_COUNT = 8;
	localparam int unsigned TAP_OFS [TAP_COUNT] = '{0, 1, 3, 4, 14, 15, 18, 19};

	// score is unsigned q1.15
	localparam int unsigned SCORE_W    = 16;
	localparam int unsigned SCORE_FRAC = 15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_OLD,
		ST_SUB_OLD,
		ST_ADD_NEW,
		ST_CHECK,
		ST_ROOT,
		ST_DONE
	} pnc_state_t;

endpackage

`default_nettype wire

// File: rtl/preamble_normalized_correlator.sv
// preamble_normalized_correlator: streaming normalized preamble correlation score
// each input beat passes SQ_OLD, SUB_OLD, ADD_NEW and CHECK, then the 16-step score search
// and DONE; a zero-energy window skips the search, and a window still filling gives no score;
//   a new input beat is taken only back in idle, so a stalled output holds off input
// reset: arst_n clears the delay line, energy sum and fill count, no result pending
// depends on pnc_pkg, pnc_delay, pnc_sq, pnc_root
`timescale 1ns / 1ps
`default_nettype none

module preamble_normalized_correlator #(
	parameter int WINDOW_LEN  = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// input channel, one magnitude sample per beat
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [pnc_pkg::SAMPLE_PORT_W-1:0]     sample,
	// output channel, one score per beat once the window is full
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic      [pnc_pkg::SCORE_W-1:0]           score,
	output logic                                       zero_energy
);

	// only the low sample bits are used, never more than the port carries
	localparam int SB = (SAMPLE_BITS < int'(pnc_pkg::SAMPLE_PORT_W)) ?
		SAMPLE_BITS : int'(pnc_pkg::SAMPLE_PORT_W);
	// tap sum width, eight taps
	localparam int CW = SB + $clog2(pnc_pkg::TAP_COUNT);
	// window energy width
	localparam int EW = 2 * SB + $clog2(WINDOW_LEN);
	// fill counter width, counts up to the window length
	localparam int FW = $clog2(WINDOW_LEN + 1);

	pnc_pkg::pnc_state_t state_q, state_d;

	logic [SB-1:0]                 old_q, x_q;
	logic [FW-1:0]                 fill_q;
	logic [EW-1:0]                 energy_q;
	logic                          zero_q;
	logic                          out_valid_q;
	logic [pnc_pkg::SCORE_W-1:0]   score_q;
	logic                          zero_out_q;

	logic                          in_acc;
	logic                          out_free;
	logic [SB-1:0]                 oldest;
	logic [CW-1:0]                 tap_sum;
	logic [CW-1:0]                 sq_a;
	logic [2*CW-1:0]               sq_p;
	logic                          root_start;
	logic                          root_done;
	logic [pnc_pkg::SCORE_W-1:0]   root_score;

	assign in_ready = (state_q == pnc_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	// output register free, or being emptied this cycle
	assign out_free = !out_valid_q || out_ready;

	// window of samples, shifts once per accepted beat
	pnc_delay #(
		.WIN (WINDOW_LEN),
		.SW  (SB),
		.CW  (CW)
	) u_delay (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (in_acc),
		.din     (sample[SB-1:0]),
		.oldest  (oldest),
		.tap_sum (tap_sum)
	);

	// one squarer serves old^2, new^2 and c^2 in successive cycles
	pnc_sq #(
		.W (CW)
	) u_sq (
		.clk (clk),
		.a   (sq_a),
		.p   (sq_p)
	);

	pnc_root #(
		.EW    (EW),
		.CSQ_W (2 * CW)
	) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.csq    (sq_p),
		.energy (energy_q),
		.done   (root_done),
		.score  (root_score)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: square out the old sample, square in the new one, square the
	// tap sum, then run the score search unless the window is short or silent
	always_comb begin
		state_d    = state_q;
		sq_a       = '0;
		root_start = 1'b0;
		unique case (state_q)
			pnc_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = pnc_pkg::ST_SQ_OLD;
				end
			end
			pnc_pkg::ST_SQ_OLD: begin
				sq_a    = CW'(old_q);
				state_d = pnc_pkg::ST_SUB_OLD;
			end
			pnc_pkg::ST_SUB_OLD: begin
				sq_a    = CW'(x_q);
				state_d = pnc_pkg::ST_ADD_NEW;
			end
			pnc_pkg::ST_ADD_NEW: begin
				sq_a    = tap_sum;
				state_d = pnc_pkg::ST_CHECK;
			end
			pnc_pkg::ST_CHECK: begin
				if (fill_q != FW'(WINDOW_LEN)) begin
					state_d = pnc_pkg::ST_IDLE;
				end else if (energy_q == '0) begin
					state_d = pnc_pkg::ST_DONE;
				end else begin
					root_start = 1'b1;
					state_d    = pnc_pkg::ST_ROOT;
				end
			end
			pnc_pkg::ST_ROOT: begin
				if (root_done) begin
					state_d = pnc_pkg::ST_DONE;
				end
			end
			pnc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pnc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pnc_pkg::ST_IDLE;
			end
		endcase
	end

	// captured sample pair for the energy update
	always_ff @(posedge clk) begin
		if (in_acc) begin
			old_q <= oldest;
			x_q   <= sample[SB-1:0];
		end
	end

	// fill count saturates at the window length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_acc && (fill_q != FW'(WINDOW_LEN))) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// running sum of squares, squares land in the cycle after they are issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			zero_q   <= 1'b0;
		end else begin
			if (state_q == pnc_pkg::ST_SUB_OLD) begin
				energy_q <= energy_q - EW'(sq_p[2*SB-1:0]);
			end else if (state_q == pnc_pkg::ST_ADD_NEW) begin
				energy_q <= energy_q + EW'(sq_p[2*SB-1:0]);
			end
			if (state_q == pnc_pkg::ST_CHECK) begin
				zero_q <= (energy_q == '0);
			end
		end
	end

	// output register, refilled while the previous beat may still be leaving
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == pnc_pkg::ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == pnc_pkg::ST_DONE) && out_free) begin
			score_q    <= zero_q ? '0 : root_score;
			zero_out_q <= zero_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign score       = score_q;
	assign zero_energy = zero_out_q;

endmodule

`default_nettype wire

// File: rtl/pnc_delay.sv
// pnc_delay: sample shift line with oldest-sample tap and correlation tap sum
// depends on pnc_pkg for the tap offsets
`timescale 1ns / 1ps
`default_nettype none

module pnc_delay #(
	parameter int WIN = 32,
	parameter int SW  = 16,
	parameter int CW  = 19
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [SW-1:0] din,
	output logic      [SW-1:0] oldest,
	output logic      [CW-1:0] tap_sum
);

	logic [SW-1:0] line_q [WIN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) begin
				line_q[i] <= '0;
			end
		end else if (push) begin
			for (int i = 0; i < WIN - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
			line_q[WIN-1] <= din;
		end
	end

	assign oldest = line_q[0];

	always_comb begin
		tap_sum = '0;
		for (int k = 0; k < int'(pnc_pkg::TAP_COUNT); k++) begin
			tap_sum = tap_sum + CW'(line_q[pnc_pkg::TAP_OFS[k]]);
		end
	end

endmodule

`default_nettype wire

// File: rtl/pnc_sq.sv
// pnc_sq: shared registered squarer used for the energy update and for c*c
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pnc_sq #(
	parameter int W = 19
) (
	input  wire logic            clk,
	input  wire logic [W-1:0]    a,
	output logic      [2*W-1:0]  p
);

	logic [2*W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * a;
	end

	assign p = p_q;

endmodule

`default_nettype wire

// File: rtl/pnc_root.sv
// pnc_root: bit-serial search for the largest s with s*s*8*e <= c*c*2^30
// one score bit per cycle with shift-and-add updates; depends on pnc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pnc_root #(
	parameter int EW    = 37,
	parameter int CSQ_W = 38
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [CSQ_W-1:0]                  csq,
	input  wire logic [EW-1:0]                     energy,
	output logic                                   done,
	output logic      [pnc_pkg::SCORE_W-1:0]       score
);

	localparam int SW  = pnc_pkg::SCORE_W;
	localparam int FR2 = 2 * pnc_pkg::SCORE_FRAC;
	// room for e*8*2^(2*frac) plus the cross term
	localparam int AW  = EW + FR2 + 6;
	localparam int NW  = $clog2(SW);

	// rem: target minus accepted s*s*d, r: s*d*2^(b+1), t: d*2^(2b), d = 8e
	logic [AW-1:0] rem_q, r_q, t_q;
	logic [SW-1:0] s_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [AW+1:0] diff;
	logic          fits;

	assign diff = {2'b00, rem_q} - {2'b00, r_q} - {2'b00, t_q};
	assign fits = ~diff[AW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= NW'(SW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= AW'(csq) << FR2;
			r_q   <= '0;
			t_q   <= AW'(energy) << (FR2 + 3);
			s_q   <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[AW-1:0];
			end
			r_q <= (r_q >> 1) + (fits ? t_q : '0);
			t_q <= t_q >> 2;
			s_q <= {s_q[SW-2:0], fits};
		end
	end

	assign done  = done_q;
	assign score = s_q;

endmodule

`default_nettype wire
